// ----- rtl/websocket_frame_deframer_defines.svh -----
// Assertion macros for the frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// Immediate-implication property, checked at every clock edge out of reset.
`define WFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies a property in the next.
`define WFD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`else
`define WFD_ASSERT(label, clk, rst, prop, msg)
`define WFD_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// ----- rtl/wfd_pkg.sv -----
`default_nettype none
package wfd_pkg;

   localparam int WFD_QUEUE_DEPTH = 4;

   localparam logic [6:0] LEN_EXT16   = 7'h7e;
   localparam logic [6:0] LEN_EXT64   = 7'h7f;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [1:0] KEY_LAST_POS = 2'd3;

   typedef enum logic [2:0] {
      PH_HDR1    = 3'd0,
      PH_HDR2    = 3'd1,
      PH_EXT     = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_DISCARD = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNMASKED  = 2'd1,
      ST_NONFINAL  = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       last_byte;
      logic       empty_frame;
      status_type status;
   } rsp_type;

   // Queued command from parser to output stage; unmasking happens downstream.
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic [3:0] opcode;
      logic       last;
      logic       empty;
      status_type status;
   } cmd_type;

endpackage
`default_nettype wire

// ----- rtl/wfd_front.sv -----
`default_nettype none
`include "websocket_frame_deframer_defines.svh"
module wfd_front
   import wfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   input  wire logic    q_full,
   output logic         push_out,
   output cmd_type      cmd_out
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [63:0] rem_ff, rem_in;
   logic [3:0]  ext_ff, ext_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  kpos_ff, kpos_in;

   logic       accept;
   logic [7:0] b;
   logic       chunk_end;
   logic [7:0] cur_key;

   assign accept    = req_push && !q_full;
   assign b         = req_data.rx_byte;
   assign chunk_end = req_data.chunk_end;
   // key byte 0 sits in the top byte
   assign cur_key   = key_ff[{~kpos_ff, 3'b000} +: 8];

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_HDR1: begin
               if (!b[7])
                  phase_in = chunk_end ? PH_HDR1 : PH_DISCARD;
               else if (chunk_end)
                  phase_in = PH_HDR1;
               else
                  phase_in = PH_HDR2;
            end
            PH_HDR2: begin
               if (!b[7])
                  phase_in = chunk_end ? PH_HDR1 : PH_DISCARD;
               else if (chunk_end)
                  phase_in = PH_HDR1;
               else if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64)
                  phase_in = PH_EXT;
               else
                  phase_in = PH_KEY;
            end
            PH_EXT: begin
               if (chunk_end)
                  phase_in = PH_HDR1;
               else if (ext_ff == 4'd1)
                  phase_in = PH_KEY;
            end
            PH_KEY: begin
               if (kpos_ff != KEY_LAST_POS)
                  phase_in = chunk_end ? PH_HDR1 : PH_KEY;
               else if (rem_ff == 64'd0)
                  phase_in = chunk_end ? PH_HDR1 : PH_DISCARD;
               else
                  phase_in = chunk_end ? PH_HDR1 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (rem_ff == 64'd1)
                  phase_in = chunk_end ? PH_HDR1 : PH_DISCARD;
               else if (chunk_end)
                  phase_in = PH_HDR1;
            end
            default: begin
               if (chunk_end)
                  phase_in = PH_HDR1;
            end
         endcase
      end
   end

   always_comb begin
      opcode_in = opcode_ff;
      rem_in    = rem_ff;
      ext_in    = ext_ff;
      key_in    = key_ff;
      kpos_in   = kpos_ff;
      push_out  = 1'b0;
      cmd_out   = '0;
      if (accept) begin
         case (phase_ff)
            PH_HDR1: begin
               opcode_in = b[3:0];
               if (!b[7]) begin
                  push_out       = 1'b1;
                  cmd_out.last   = 1'b1;
                  cmd_out.status = ST_NONFINAL;
               end else if (chunk_end) begin
                  push_out       = 1'b1;
                  cmd_out.last   = 1'b1;
                  cmd_out.status = ST_TRUNCATED;
               end
            end
            PH_HDR2: begin
               if (!b[7]) begin
                  push_out       = 1'b1;
                  cmd_out.last   = 1'b1;
                  cmd_out.status = ST_UNMASKED;
               end else if (chunk_end) begin
                  push_out       = 1'b1;
                  cmd_out.last   = 1'b1;
                  cmd_out.status = ST_TRUNCATED;
               end else begin
                  kpos_in = 2'd0;
                  key_in  = 32'd0;
                  rem_in  = 64'd0;
                  if (b[6:0] == LEN_EXT16)
                     ext_in = EXT16_BYTES;
                  else if (b[6:0] == LEN_EXT64)
                     ext_in = EXT64_BYTES;
                  else
                     rem_in = {57'd0, b[6:0]};
               end
            end
            PH_EXT: begin
               if (chunk_end) begin
                  push_out       = 1'b1;
                  cmd_out.last   = 1'b1;
                  cmd_out.status = ST_TRUNCATED;
               end else begin
                  rem_in = {rem_ff[55:0], b};
                  ext_in = ext_ff - 4'd1;
               end
            end
            PH_KEY: begin
               key_in  = {key_ff[23:0], b};
               kpos_in = kpos_ff + 2'd1;
               if (kpos_ff == KEY_LAST_POS && rem_ff == 64'd0) begin
                  push_out       = 1'b1;
                  cmd_out.last   = 1'b1;
                  cmd_out.empty  = 1'b1;
                  cmd_out.status = ST_OK;
               end else if (chunk_end) begin
                  push_out       = 1'b1;
                  cmd_out.last   = 1'b1;
                  cmd_out.status = ST_TRUNCATED;
               end
            end
            PH_PAYLOAD: begin
               rem_in   = rem_ff - 64'd1;
               kpos_in  = kpos_ff + 2'd1;
               push_out = 1'b1;
               if (rem_ff == 64'd1) begin
                  cmd_out.data = b;
                  cmd_out.key  = cur_key;
                  cmd_out.last = 1'b1;
               end else if (chunk_end) begin
                  // drop the byte, report truncation
                  cmd_out.last   = 1'b1;
                  cmd_out.status = ST_TRUNCATED;
               end else begin
                  cmd_out.data = b;
                  cmd_out.key  = cur_key;
               end
            end
            default: begin
            end
         endcase
      end
      cmd_out.opcode = opcode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR1;
         opcode_ff <= 4'd0;
         rem_ff    <= 64'd0;
         ext_ff    <= 4'd0;
         key_ff    <= 32'd0;
         kpos_ff   <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         rem_ff    <= rem_in;
         ext_ff    <= ext_in;
         key_ff    <= key_in;
         kpos_ff   <= kpos_in;
      end
   end

   `WFD_ASSERT(a_discard_silent, clock, reset, (accept && phase_ff == PH_DISCARD) |-> !push_out, "result pushed while discarding trailing bytes")
   `WFD_ASSERT(a_midframe_only_payload, clock, reset, (push_out && !cmd_out.last) |-> (phase_ff == PH_PAYLOAD), "non-final result outside payload phase")

endmodule
`default_nettype wire

// ----- rtl/wfd_queue.sv -----
`default_nettype none
`include "websocket_frame_deframer_defines.svh"
module wfd_queue
   import wfd_pkg::*;
#(
   parameter int DEPTH = WFD_QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entries_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `WFD_ASSERT(a_no_overflow, clock, reset, push |-> !full, "push into full queue")
   `WFD_ASSERT(a_no_underflow, clock, reset, pop |-> !empty, "pop from empty queue")

endmodule
`default_nettype wire

// ----- rtl/wfd_back.sv -----
`default_nettype none
`include "websocket_frame_deframer_defines.svh"
module wfd_back
   import wfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type q_head,
   input  wire logic    q_empty,
   output logic         q_pop,
   input  wire logic    rsp_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // refill the output register whenever it is free or being drained
   assign q_pop = !q_empty && (!valid_ff || rsp_pop);

   always_comb begin
      data_in              = data_ff;
      valid_in             = valid_ff && !rsp_pop;
      if (q_pop) begin
         valid_in             = 1'b1;
         data_in.payload_byte = q_head.data ^ q_head.key;
         data_in.frame_opcode = q_head.opcode;
         data_in.last_byte    = q_head.last;
         data_in.empty_frame  = q_head.empty;
         data_in.status       = q_head.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = data_ff;

   `WFD_ASSERT_NEXT(a_fill_when_idle, clock, reset, (!valid_ff && !q_empty), valid_ff, "output stage did not load a waiting result")

endmodule
`default_nettype wire

// ----- rtl/websocket_frame_deframer.sv -----
// A result reaches rsp_data through the command queue and then the output register.
// Throughput: one byte per cycle while req_full is low; the header parser handles every accepted byte.
// Output side stalls are absorbed by a QUEUE_DEPTH-entry command queue plus the
// output register; req_full rises only when both are occupied.
// Reset (synchronous, active high) returns the parser to the first header byte,
// clears all frame state and empties the queue and output register.
`default_nettype none
module websocket_frame_deframer
   import wfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = WFD_QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   // input channel: one received byte per transaction
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   // result channel: at most one result per accepted byte
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   cmd_type front_cmd;
   logic    front_push;
   cmd_type q_head;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   // Parse header, extended length and mask key; turn each payload byte,
   // empty frame or error into one queued command.
   wfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .push_out (front_push),
      .cmd_out  (front_cmd)
   );

   // Decouple the parser from output stalls.
   wfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Unmask the data byte and hold the result until it is taken.
   wfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // Refuse new bytes only while the queue has no room.
   assign req_full = q_full;

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top;
   import wfd_pkg::*;

   // Give up well past the slowest legal run (~1000 bytes plus trailing and stalls).
   localparam int CYCLE_LIMIT = 200000;
   localparam int BYTE_TARGET = 1000;
   localparam int IDLE_PCT    = 12;
   localparam int PRINT_LIMIT = 40;

   // One row of the directed table: a byte, and optionally its result typed in by hand.
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type result;
   } stim_row;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    req_push   = 1'b0;
   req_type req_data   = '0;
   logic    rsp_pop    = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;

   // Side band that travels with req_data: a hand-typed expectation for this byte.
   logic    row_typed  = 1'b0;
   rsp_type row_result = '0;

   // Suppress random idling on both sides while set.
   logic    calm        = 1'b0;
   int      sent_count  = 0;
   int      error_count = 0;
   int      cycle_count = 0;

   rsp_type pending_results[$];

   // Deframer state as seen by the predictor.
   phase_type   frame_phase = PH_HDR1;
   logic [3:0]  held_opcode = '0;
   logic [63:0] bytes_to_go = '0;
   logic [3:0]  ext_to_go   = '0;
   logic [31:0] unmask_key  = '0;
   logic [1:0]  key_index   = '0;

   stim_row directed_rows[$];

   websocket_frame_deframer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Error result: restart on a chunk end, otherwise drop the rest of the chunk.
   function automatic rsp_type fail_frame(input status_type st, input logic end_flag);
      rsp_type res;
      res.payload_byte = 8'h00;
      res.frame_opcode = held_opcode;
      res.last_byte    = 1'b1;
      res.empty_frame  = 1'b0;
      res.status       = st;
      frame_phase      = end_flag ? PH_HDR1 : PH_DISCARD;
      return res;
   endfunction

   // Advance the deframer by one byte; return 1 when the byte yields a result.
   function automatic logic deframe_byte(input req_type item, output rsp_type res);
      logic [7:0] b;
      logic       end_flag;
      logic [7:0] key_byte;
      b        = item.rx_byte;
      end_flag = item.chunk_end;
      res      = '0;
      case (frame_phase)
         PH_HDR1: begin
            held_opcode = b[3:0];
            if (!b[7]) begin
               res = fail_frame(ST_NONFINAL, end_flag);
               return 1'b1;
            end
            if (end_flag) begin
               res = fail_frame(ST_TRUNCATED, 1'b1);
               return 1'b1;
            end
            frame_phase = PH_HDR2;
            return 1'b0;
         end
         PH_HDR2: begin
            // Missing mask wins over a chunk end on the same byte.
            if (!b[7]) begin
               res = fail_frame(ST_UNMASKED, end_flag);
               return 1'b1;
            end
            if (end_flag) begin
               res = fail_frame(ST_TRUNCATED, 1'b1);
               return 1'b1;
            end
            bytes_to_go = '0;
            key_index   = '0;
            unmask_key  = '0;
            if (b[6:0] == LEN_EXT16) begin
               ext_to_go   = EXT16_BYTES;
               frame_phase = PH_EXT;
            end else if (b[6:0] == LEN_EXT64) begin
               ext_to_go   = EXT64_BYTES;
               frame_phase = PH_EXT;
            end else begin
               bytes_to_go = {57'd0, b[6:0]};
               frame_phase = PH_KEY;
            end
            return 1'b0;
         end
         PH_EXT: begin
            if (end_flag) begin
               res = fail_frame(ST_TRUNCATED, 1'b1);
               return 1'b1;
            end
            bytes_to_go = {bytes_to_go[55:0], b};
            ext_to_go   = ext_to_go - 4'd1;
            if (ext_to_go == 4'd0)
               frame_phase = PH_KEY;
            return 1'b0;
         end
         PH_KEY: begin
            unmask_key = {unmask_key[23:0], b};
            key_index  = key_index + 2'd1;
            if (key_index != 2'd0) begin
               if (end_flag) begin
                  res = fail_frame(ST_TRUNCATED, 1'b1);
                  return 1'b1;
               end
               return 1'b0;
            end
            // Zero-length frame: one empty result right after the key.
            if (bytes_to_go == 64'd0) begin
               res = {8'h00, held_opcode, 1'b1, 1'b1, ST_OK};
               frame_phase = end_flag ? PH_HDR1 : PH_DISCARD;
               return 1'b1;
            end
            if (end_flag) begin
               res = fail_frame(ST_TRUNCATED, 1'b1);
               return 1'b1;
            end
            frame_phase = PH_PAYLOAD;
            return 1'b0;
         end
         PH_PAYLOAD: begin
            key_byte    = unmask_key[8 * (3 - key_index) +: 8];
            bytes_to_go = bytes_to_go - 64'd1;
            key_index   = key_index + 2'd1;
            if (bytes_to_go == 64'd0) begin
               res = {b ^ key_byte, held_opcode, 1'b1, 1'b0, ST_OK};
               frame_phase = end_flag ? PH_HDR1 : PH_DISCARD;
               return 1'b1;
            end
            // A chunk end short of the payload end drops the byte it carries.
            if (end_flag) begin
               res = fail_frame(ST_TRUNCATED, 1'b1);
               return 1'b1;
            end
            res = {b ^ key_byte, held_opcode, 1'b0, 1'b0, ST_OK};
            return 1'b1;
         end
         default: begin
            // Trailing bytes: drop until the chunk end.
            if (end_flag)
               frame_phase = PH_HDR1;
            return 1'b0;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("MISMATCH cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
   endtask

   // Check the popped result first, then predict from the byte accepted at this edge;
   // a new byte cannot show up on the result side in the same cycle.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type model_rsp;
      logic    model_has;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result, payload_byte", rsp_data.payload_byte, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", rsp_data.payload_byte, want.payload_byte);
               if (rsp_data.frame_opcode !== want.frame_opcode)
                  report_mismatch("frame_opcode", rsp_data.frame_opcode, want.frame_opcode);
               if (rsp_data.last_byte !== want.last_byte)
                  report_mismatch("last_byte", rsp_data.last_byte, want.last_byte);
               if (rsp_data.empty_frame !== want.empty_frame)
                  report_mismatch("empty_frame", rsp_data.empty_frame, want.empty_frame);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
            end
         end
         if (req_push && !req_full) begin
            model_has = deframe_byte(req_data, model_rsp);
            // A hand-typed row overrides the predictor; the state still advances.
            if (row_typed)
               pending_results.push_back(row_result);
            else if (model_has)
               pending_results.push_back(model_rsp);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result side: pop at random, except during the calm stretch
   // ------------------------------------------------------------------

   always @(negedge clock)
      rsp_pop = calm || ($urandom_range(99) >= IDLE_PCT);

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function automatic stim_row row(input logic [7:0] b, input logic end_flag,
                                   input logic typed = 1'b0, input rsp_type r = '0);
      stim_row s;
      s.item.rx_byte   = b;
      s.item.chunk_end = end_flag;
      s.typed          = typed;
      s.result         = r;
      return s;
   endfunction

   function automatic req_type byte_item(input logic [7:0] b);
      req_type one;
      one.rx_byte   = b;
      one.chunk_end = 1'b0;
      return one;
   endfunction

   // Hold the transaction on the inputs until it is accepted; idle before it at random.
   task automatic send_byte(input req_type item, input logic typed, input rsp_type result);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push   = 1'b1;
      req_data   = item;
      row_typed  = typed;
      row_result = result;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      @(negedge clock);
   endtask

   // One chunk: mostly a well-formed masked frame with random content,
   // sometimes broken (non-final, unmasked, cut short) or plain noise.
   task automatic send_chunk();
      req_type     chunk[$];
      req_type     one;
      logic [63:0] length;
      logic [7:0]  hdr1;
      logic [7:0]  hdr2;
      logic [6:0]  len_code;
      int          kind;
      int          form;
      int          n_ext;
      int          n_pay;
      int          cut;
      int          trail;
      kind = $urandom_range(99);
      if (kind < 6) begin
         // Noise: random bytes, scattered chunk ends, closed by a chunk end.
         n_pay = $urandom_range(8, 1);
         for (int i = 0; i < n_pay; i++) begin
            one.rx_byte   = 8'($urandom);
            one.chunk_end = ($urandom_range(99) < 25) || (i == n_pay - 1);
            chunk.push_back(one);
         end
         sent_count += n_pay;
      end else begin
         hdr1 = {1'b1, 3'($urandom), 4'($urandom)};
         if (kind < 11)
            hdr1[7] = 1'b0;
         form  = $urandom_range(99);
         n_ext = 0;
         if (form < 70) begin
            length   = 64'($urandom_range(12));
            len_code = length[6:0];
         end else if (form < 78) begin
            length   = 64'($urandom_range(125));
            len_code = length[6:0];
         end else if (form < 90) begin
            length   = ($urandom_range(2) == 0) ? 64'($urandom_range(65535))
                                                : 64'($urandom_range(40));
            len_code = LEN_EXT16;
            n_ext    = 2;
         end else begin
            length   = ($urandom_range(2) == 0) ? {$urandom, $urandom}
                                                : 64'($urandom_range(12));
            len_code = LEN_EXT64;
            n_ext    = 8;
         end
         hdr2 = {1'b1, len_code};
         if (kind >= 11 && kind < 16)
            hdr2[7] = 1'b0;
         chunk.push_back(byte_item(hdr1));
         chunk.push_back(byte_item(hdr2));
         for (int i = n_ext - 1; i >= 0; i--)
            chunk.push_back(byte_item(length[8 * i +: 8]));
         for (int i = 0; i < 4; i++)
            chunk.push_back(byte_item(8'($urandom)));
         // Huge lengths never finish: send a few payload bytes and cut the chunk.
         n_pay = (length > 64'd200) ? 20 : int'(length);
         for (int i = 0; i < n_pay; i++)
            chunk.push_back(byte_item(8'($urandom)));
         if (length > 64'd200 || $urandom_range(99) < 12) begin
            cut = $urandom_range(chunk.size() - 1);
            while (chunk.size() > cut + 1)
               void'(chunk.pop_back());
            sent_count += chunk.size();
         end else begin
            sent_count += chunk.size();
            trail = ($urandom_range(99) < 30) ? $urandom_range(3, 1) : 0;
            for (int i = 0; i < trail; i++)
               chunk.push_back(byte_item(8'($urandom)));
         end
         chunk[chunk.size() - 1].chunk_end = 1'b1;
      end
      foreach (chunk[i])
         send_byte(chunk[i], 1'b0, '0);
   endtask

   initial begin
      directed_rows = '{
         // FIN clear: non-final error, rest of the chunk dropped
         row(8'h01, 1'b0, 1'b1, '{8'h00, 4'h1, 1'b1, 1'b0, ST_NONFINAL}),
         row(8'h55, 1'b1),
         // chunk end on the first header byte
         row(8'h8a, 1'b1, 1'b1, '{8'h00, 4'ha, 1'b1, 1'b0, ST_TRUNCATED}),
         // mask clear with a chunk end on the same byte: unmasked wins
         row(8'h81, 1'b0),
         row(8'h05, 1'b1, 1'b1, '{8'h00, 4'h1, 1'b1, 1'b0, ST_UNMASKED}),
         // zero-length frame: one empty result after the key
         row(8'h89, 1'b0),
         row(8'h80, 1'b0),
         row(8'h12, 1'b0),
         row(8'h34, 1'b0),
         row(8'h56, 1'b0),
         row(8'h78, 1'b1, 1'b1, '{8'h00, 4'h9, 1'b1, 1'b1, ST_OK}),
         // 16-bit extended length of one, all-ones key, then a trailing byte
         row(8'h82, 1'b0),
         row(8'hfe, 1'b0),
         row(8'h00, 1'b0),
         row(8'h01, 1'b0),
         row(8'hff, 1'b0),
         row(8'hff, 1'b0),
         row(8'hff, 1'b0),
         row(8'hff, 1'b0),
         row(8'h00, 1'b0),
         row(8'h12, 1'b1),
         // 64-bit length with the top bit set, cut inside the extension
         row(8'h8f, 1'b0),
         row(8'hff, 1'b0),
         row(8'h80, 1'b1, 1'b1, '{8'h00, 4'hf, 1'b1, 1'b0, ST_TRUNCATED})
      };

      // Hold reset, then release it at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

      while (sent_count < BYTE_TARGET) begin
         calm = (sent_count >= 450 && sent_count < 600);
         send_chunk();
      end
      calm     = 1'b0;
      req_push = 1'b0;

      // Drain: wait for every expected result, then let the pipeline settle.
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
